FILE: rtl/core/cdsrch_pkg.sv
// shared widths, constants and codes for the clock divisor search block
`default_nettype none

package cdsrch_pkg;

  localparam int N_W     = 27;          // base clock and quotient n
  localparam int HZ_W    = 32;          // requested frequency
  localparam int DIV_W   = 16;          // counter divisor width
  localparam int DVD_W   = N_W + 2;     // dividend of the serial divider (2n + lv)
  localparam int DVS_W   = 32;          // divisor of the serial divider
  localparam int ROOT_W  = (N_W + 1) / 2;
  localparam int SQREM_W = ROOT_W + 1;

  localparam logic [N_W-1:0] ROOT_CLOCK_RESET = N_W'(10000000);

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_ZERO_FREQ = 1'b1
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdsrch_div.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module cdsrch_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [cdsrch_pkg::DVD_W-1:0]  dividend,
  input  wire logic [cdsrch_pkg::DVS_W-1:0]  divisor,
  output logic                               done,
  output logic [cdsrch_pkg::DVD_W-1:0]       quot,
  output logic [cdsrch_pkg::DVS_W-1:0]       rem
);

  localparam int STEPS = cdsrch_pkg::DVD_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [cdsrch_pkg::DVS_W-1:0]  dvs;
  logic [cdsrch_pkg::DVS_W:0]    partial;
  logic [cdsrch_pkg::DVS_W:0]    diff;
  logic                          fits;

  assign partial = {rem, quot[cdsrch_pkg::DVD_W-1]};
  assign diff    = partial - {1'b0, dvs};
  assign fits    = partial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= diff[cdsrch_pkg::DVS_W-1:0];
        end else begin
          rem <= partial[cdsrch_pkg::DVS_W-1:0];
        end
        quot <= {quot[cdsrch_pkg::DVD_W-2:0], fits};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdsrch_sqrt.sv
// bit-pair integer square root with remainder, one root bit per cycle
`default_nettype none

module cdsrch_sqrt (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [cdsrch_pkg::N_W-1:0]      value,
  output logic                                 done,
  output logic [cdsrch_pkg::ROOT_W-1:0]        root,
  output logic [cdsrch_pkg::SQREM_W-1:0]       rem
);

  localparam int W     = cdsrch_pkg::N_W;
  localparam int STEPS = cdsrch_pkg::ROOT_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     num;
  logic [W-1:0]     res;
  logic [W-1:0]     bitm;
  logic [W:0]       trial;
  logic             take;

  assign trial = {1'b0, res} + {1'b0, bitm};
  assign take  = {1'b0, num} >= trial;
  assign root  = res[cdsrch_pkg::ROOT_W-1:0];
  assign rem   = num[cdsrch_pkg::SQREM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= value;
        res  <= '0;
        bitm <= W'(1) << (2 * (STEPS - 1));
      end else if (busy) begin
        if (take) begin
          num <= num - trial[W-1:0];
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/two_stage_clock_divisor_search_unit.sv
// two-stage clock divisor search: sequencer around a shared serial divider
//
//   channel | signals                          | direction
//   req     | req_valid, req_stall, hz         | in  (one frequency per transfer)
//   rsp     | rsp_valid, rsp_stall,            | out (one result per transfer)
//           | divisor_a, divisor_b, status     |
//   cfg     | cfg_valid, cfg_ready, cfg_data   | in  (root_clock register)
//
// zero and fast requests skip the divider and the root; otherwise each of the k
// candidate divisors walked (k at most about 11600) takes one pass of the
// serial divider, which yields one quotient bit per cycle.
// req_stall is high from the accepting transfer until the result is in the
// output register; a stalled result holds while the next request is worked on.
// rst is synchronous; root_clock resets to 10000000.
`default_nettype none

module two_stage_clock_divisor_search_unit #(
  parameter int DIVISOR_MAX = 65535
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic [cdsrch_pkg::HZ_W-1:0]    hz,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic [cdsrch_pkg::DIV_W-1:0]        divisor_a,
  output logic [cdsrch_pkg::DIV_W-1:0]        divisor_b,
  output logic                                status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cdsrch_pkg::N_W-1:0]     cfg_data
);

  localparam int N_W   = cdsrch_pkg::N_W;
  localparam int D_W   = cdsrch_pkg::DIV_W;
  localparam int E_W   = D_W + 1;
  localparam logic [D_W-1:0] DMAX    = D_W'(DIVISOR_MAX);
  localparam logic [32:0]    DMAX_SQ = 33'(DIVISOR_MAX) * 33'(DIVISOR_MAX);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_NDIV = 8'b0000_0010,
    S_SQRT = 8'b0000_0100,
    S_LOOP = 8'b0000_1000,
    S_CDIV = 8'b0001_0000,
    S_LAST = 8'b0010_0000,
    S_ADIV = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [N_W-1:0]        root_clock;
  logic [N_W-1:0]        n;
  logic [D_W-1:0]        lv;
  logic [D_W-1:0]        best_b;
  logic [E_W-1:0]        min_err;
  logic [D_W-1:0]        cur_a;
  logic [D_W-1:0]        cur_b;
  cdsrch_pkg::status_t   cur_status;

  logic                              req_take;
  logic                              hz_zero;
  logic                              hz_fast;
  logic                              div_start;
  logic [cdsrch_pkg::DVD_W-1:0]      div_dividend;
  logic [cdsrch_pkg::DVS_W-1:0]      div_divisor;
  logic                              div_done;
  logic [cdsrch_pkg::DVD_W-1:0]      div_quot;
  logic [cdsrch_pkg::DVS_W-1:0]      div_rem;
  logic                              sq_start;
  logic                              sq_done;
  logic [cdsrch_pkg::ROOT_W-1:0]     sq_root;
  logic [cdsrch_pkg::SQREM_W-1:0]    sq_rem;
  logic                              round_up;
  logic [D_W-1:0]                    r_round;
  logic [E_W-1:0]                    err_init;
  logic [E_W-1:0]                    c_rem;
  logic [E_W-1:0]                    c_diff;
  logic [E_W-1:0]                    c_err;
  logic                              out_free;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign hz_zero = (hz == '0);
  assign hz_fast = {hz, 2'b00} >= (cdsrch_pkg::HZ_W + 2)'(root_clock);

  // rounded root and its error, straight from the root remainder
  assign round_up = {1'b0, sq_rem} > (cdsrch_pkg::SQREM_W + 1)'(sq_root);
  assign r_round  = D_W'(sq_root) + D_W'(round_up);
  assign err_init = round_up ? (E_W'(sq_root) << 1) + E_W'(1) - E_W'(sq_rem)
                             : E_W'(sq_rem);

  // (2n + lv) = q * 2lv + rem gives n - q*lv = (rem - lv) / 2
  assign c_rem  = div_rem[E_W-1:0];
  assign c_diff = (c_rem >= E_W'(lv)) ? c_rem - E_W'(lv) : E_W'(lv) - c_rem;
  assign c_err  = c_diff >> 1;

  assign sq_start = (state == S_NDIV) && div_done
                    && !(33'(div_quot) > DMAX_SQ);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = cdsrch_pkg::DVD_W'(root_clock);
    div_divisor  = hz;
    unique case (state)
      S_IDLE: div_start = req_take && !hz_zero && !hz_fast;
      S_LOOP: begin
        div_start    = (lv >= D_W'(2));
        div_dividend = {2'b00, n} + {2'b00, n} + cdsrch_pkg::DVD_W'(lv);
        div_divisor  = cdsrch_pkg::DVS_W'({lv, 1'b0});
      end
      S_LAST: begin
        div_start    = 1'b1;
        div_dividend = cdsrch_pkg::DVD_W'(n);
        div_divisor  = cdsrch_pkg::DVS_W'(best_b);
      end
      S_NDIV, S_SQRT, S_CDIV, S_ADIV, S_FIN: ;
      default: ;
    endcase
  end

  cdsrch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  cdsrch_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (div_quot[N_W-1:0]),
    .done  (sq_done),
    .root  (sq_root),
    .rem   (sq_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_clock <= cdsrch_pkg::ROOT_CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      root_clock <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            if (hz_zero) begin
              cur_a      <= '0;
              cur_b      <= '0;
              cur_status <= cdsrch_pkg::STATUS_ZERO_FREQ;
              state      <= S_FIN;
            end else if (hz_fast) begin
              cur_a      <= D_W'(2);
              cur_b      <= D_W'(2);
              cur_status <= cdsrch_pkg::STATUS_OK;
              state      <= S_FIN;
            end else begin
              cur_status <= cdsrch_pkg::STATUS_OK;
              state      <= S_NDIV;
            end
          end
        end
        S_NDIV: begin
          if (div_done) begin
            n <= div_quot[N_W-1:0];
            if (sq_start) begin
              state <= S_SQRT;
            end else begin
              // root beyond divisor range
              cur_a <= DMAX;
              cur_b <= DMAX;
              state <= S_FIN;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            best_b  <= r_round;
            lv      <= r_round;
            min_err <= err_init;
            state   <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (lv >= D_W'(2)) begin
            state <= S_CDIV;
          end else begin
            state <= S_LAST;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            if (div_quot > cdsrch_pkg::DVD_W'(DIVISOR_MAX)) begin
              state <= S_LAST;
            end else if (c_err == '0) begin
              best_b <= lv;
              state  <= S_LAST;
            end else begin
              if (c_err < min_err) begin
                best_b  <= lv;
                min_err <= c_err;
              end
              lv    <= lv - D_W'(1);
              state <= S_LOOP;
            end
          end
        end
        S_LAST: state <= S_ADIV;
        S_ADIV: begin
          if (div_done) begin
            cur_a <= (div_quot > cdsrch_pkg::DVD_W'(DIVISOR_MAX)) ? DMAX
                                                                  : div_quot[D_W-1:0];
            cur_b <= best_b;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            divisor_a <= cur_a;
            divisor_b <= cur_b;
            status    <= cur_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_zero_divisors: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cdsrch_pkg::STATUS_ZERO_FREQ
      |-> divisor_a == '0 && divisor_b == '0)
    else $error("error status with non-zero divisors");

  a_ok_divisors_usable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cdsrch_pkg::STATUS_OK
      |-> divisor_b >= D_W'(2) && divisor_a != '0)
    else $error("successful result with unusable divisor");

  a_candidate_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CDIV |-> lv >= D_W'(2) && best_b >= lv)
    else $error("candidate divisor outside the search range");

  a_result_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FIN))
    else $error("result transfer raised outside the final state");

endmodule

`default_nettype wire

FILE: test/two_stage_clock_divisor_search_checker.sv
// checker for the divisor search unit: predicts each result and compares transfers
`timescale 1ns / 1ps

module two_stage_clock_divisor_search_checker #(
  parameter int DIVISOR_MAX = 65535
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  logic [cdsrch_pkg::HZ_W-1:0]       hz,
  input  logic                              rsp_valid,
  input  logic                              rsp_stall,
  input  logic [cdsrch_pkg::DIV_W-1:0]      divisor_a,
  input  logic [cdsrch_pkg::DIV_W-1:0]      divisor_b,
  input  logic                              status,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cdsrch_pkg::N_W-1:0]        cfg_data,
  output int                                fail_count,
  output int                                pending
);

  localparam int REPORT_LIMIT = 10;
  localparam int DIV_W        = cdsrch_pkg::DIV_W;

  typedef struct packed {
    logic [DIV_W-1:0]    div_a;
    logic [DIV_W-1:0]    div_b;
    cdsrch_pkg::status_t st;
  } divisor_result_t;

  divisor_result_t                 expected_divisors[$];
  logic [cdsrch_pkg::N_W-1:0]      base_clock = cdsrch_pkg::ROOT_CLOCK_RESET;
  int                              fail_total = 0;

  function automatic logic [63:0] abs_gap(input logic [63:0] x, input logic [63:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  function automatic divisor_result_t search_divisors(
      input logic [cdsrch_pkg::HZ_W-1:0] f,
      input logic [cdsrch_pkg::N_W-1:0]  base);
    divisor_result_t res;
    logic [63:0] dmax, n, r, lv, cand, err, min_err, best, quot;
    dmax      = 64'(DIVISOR_MAX);
    res.div_a = '0;
    res.div_b = '0;
    res.st    = cdsrch_pkg::STATUS_OK;
    if (f == '0) begin
      res.st = cdsrch_pkg::STATUS_ZERO_FREQ;
    end else if ((64'(f) << 2) >= 64'(base)) begin
      res.div_a = DIV_W'(2);
      res.div_b = DIV_W'(2);
    end else begin
      n = 64'(base) / 64'(f);
      if (n > dmax * dmax) begin
        res.div_a = DIV_W'(dmax);
        res.div_b = DIV_W'(dmax);
      end else begin
        // floor root bit by bit, then round to nearest
        r = '0;
        for (int i = 14; i >= 0; i--) begin
          if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= n) r = r | (64'd1 << i);
        end
        if (n - r * r > r) r = r + 1;
        best    = r;
        min_err = abs_gap(n, r * r);
        for (lv = r; lv >= 2; lv = lv - 1) begin
          cand = (2 * n + lv) / (2 * lv);
          if (cand > dmax) break;
          err = abs_gap(n, cand * lv);
          if (err == 0) begin
            best = lv;
            break;
          end
          if (err < min_err) begin
            best    = lv;
            min_err = err;
          end
        end
        if (best == 0) best = 1;
        quot = n / best;
        if (quot > dmax) quot = dmax;
        if (best > dmax) best = dmax;
        res.div_a = quot[DIV_W-1:0];
        res.div_b = best[DIV_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    divisor_result_t want;
    divisor_result_t got;
    if (rst) begin
      base_clock = cdsrch_pkg::ROOT_CLOCK_RESET;
      expected_divisors.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got.div_a = divisor_a;
        got.div_b = divisor_b;
        got.st    = cdsrch_pkg::status_t'(status);
        if (expected_divisors.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: result transfer with nothing expected: a=%0d b=%0d status=%0d",
                     $realtime, got.div_a, got.div_b, got.st);
        end else begin
          want = expected_divisors.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: mismatch: expected a=%0d b=%0d status=%0d, got a=%0d b=%0d status=%0d",
                       $realtime, want.div_a, want.div_b, want.st,
                       got.div_a, got.div_b, got.st);
          end
        end
      end
      if (req_valid && !req_stall) expected_divisors.push_back(search_divisors(hz, base_clock));
      if (cfg_valid && cfg_ready) base_clock = cfg_data;
    end
    fail_count <= fail_total;
    pending    <= expected_divisors.size();
  end

endmodule

FILE: test/tb_two_stage_clock_divisor_search_unit.sv
// testbench top for the divisor search unit: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_two_stage_clock_divisor_search_unit;

  localparam int DIVISOR_MAX    = 65535;
  localparam int IDLE_LIGHT     = 29;
  localparam int IDLE_HEAVY     = 46;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_SET  = 10;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int HZ_W           = cdsrch_pkg::HZ_W;
  localparam int DIV_W          = cdsrch_pkg::DIV_W;
  localparam int N_W            = cdsrch_pkg::N_W;

  typedef enum int {
    SEND_LIGHT_RECV_HEAVY,
    SEND_HEAVY_RECV_LIGHT,
    NO_IDLE
  } idle_mode_t;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [HZ_W-1:0]   hz;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [DIV_W-1:0]  divisor_a;
  logic [DIV_W-1:0]  divisor_b;
  logic              status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [N_W-1:0]    cfg_data;

  int         fail_count;
  int         pending;
  idle_mode_t idle_mode;
  logic       pressure_go;
  logic [N_W-1:0] cur_root;
  int         sent_total;
  int         settings_total;

  two_stage_clock_divisor_search_unit #(
    .DIVISOR_MAX (DIVISOR_MAX)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .hz        (hz),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .divisor_a (divisor_a),
    .divisor_b (divisor_b),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  two_stage_clock_divisor_search_checker #(
    .DIVISOR_MAX (DIVISOR_MAX)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .hz         (hz),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .divisor_a  (divisor_a),
    .divisor_b  (divisor_b),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly small quotients keep the candidate walk short; a few reach further
  function automatic logic [HZ_W-1:0] random_freq(input logic [N_W-1:0] base);
    int unsigned pick;
    logic [31:0] n_target;
    logic [HZ_W-1:0] f;
    pick = $urandom_range(99);
    if (pick < 15) begin
      f = $urandom;
    end else if (pick < 17) begin
      f = '0;
    end else if (pick < 25) begin
      // either side of the fast-request boundary
      f = HZ_W'((64'(base) + 3) >> 2);
      if ($urandom_range(1) == 1 && f != '0) f = f - 1;
    end else begin
      if (pick < 28) n_target = $urandom_range(500000, 20001);
      else n_target = $urandom_range(20000, 4);
      f = HZ_W'(32'(base) / n_target);
      if (f == '0) f = 1;
    end
    return f;
  endfunction

  task automatic send_freq(input logic [HZ_W-1:0] f);
    while ($urandom_range(99) < ((idle_mode == SEND_LIGHT_RECV_HEAVY) ? IDLE_LIGHT :
                                 (idle_mode == SEND_HEAVY_RECV_LIGHT) ? IDLE_HEAVY : 0)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    hz        <= f;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_total++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_root(input logic [N_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_root = v;
    settings_total++;
  endtask

  // receiver: random stalls, plus one long hold-off while the sender keeps offering
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(99) < ((idle_mode == SEND_LIGHT_RECV_HEAVY) ? IDLE_HEAVY :
                                          (idle_mode == SEND_HEAVY_RECV_LIGHT) ? IDLE_LIGHT : 0));
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_two_stage_clock_divisor_search_unit: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [N_W-1:0] phase_roots [7];
    rst            = 1'b1;
    req_valid      = 1'b0;
    hz             = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    idle_mode      = SEND_LIGHT_RECV_HEAVY;
    pressure_go    = 1'b0;
    cur_root       = cdsrch_pkg::ROOT_CLOCK_RESET;
    sent_total     = 0;
    settings_total = 0;

    phase_roots[0] = N_W'(100000000);
    phase_roots[1] = N_W'(4);
    phase_roots[2] = '0;
    phase_roots[3] = '1;
    phase_roots[4] = N_W'($urandom_range(100000000, 4));
    phase_roots[5] = N_W'($urandom_range(100000000, 4));
    phase_roots[6] = cdsrch_pkg::ROOT_CLOCK_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners at the reset base clock
    send_freq(32'd0);
    send_freq(32'd1);              // largest quotient at this base clock
    send_freq(32'hFFFF_FFFF);
    send_freq(32'd2500000);        // hz*4 equals the base clock
    send_freq(32'd2499999);        // just below the fast boundary
    send_freq(32'd10000000);
    send_freq(32'd3);
    send_freq(32'd7);
    send_freq(32'd100);
    send_freq(32'd1000);           // exact square, zero error at once
    send_freq(32'd12345);
    send_freq(32'd152);
    send_freq(32'd0);
    send_freq(32'd10000);
    send_freq(32'd33333);
    send_freq(32'h8000_0000);
    send_freq(32'h0000_FFFF);
    send_freq(32'hAAAA_AAAA);
    send_freq(32'h0000_5555);

    // long receiver hold-off with fast requests queued behind it
    pressure_go <= 1'b1;
    repeat (8) send_freq(HZ_W'($urandom_range(32'hFFFF_FFFF, 32'd2500000)));

    for (int p = 0; p < 7; p++) begin
      if (p == 3) idle_mode <= SEND_HEAVY_RECV_LIGHT;
      if (p == 5) idle_mode <= NO_IDLE;
      drain();
      write_root(phase_roots[p]);
      if (p == 0) send_freq(32'd1);  // largest quotient at this base clock, an exact square
      repeat (ITEMS_PER_SET) send_freq(random_freq(cur_root));
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d frequency requests over %0d base clock settings after reset",
             sent_total, settings_total);
    $display("base clocks included zero, 4, 100 MHz and the full 27-bit value, three idle mixes");
    if (fail_count == 0 && pending == 0)
      $display("tb_two_stage_clock_divisor_search_unit: done, clean");
    else
      $display("tb_two_stage_clock_divisor_search_unit: done, errors");
    $finish;
  end

endmodule
